// ----- hdl/rcfog_pkg.sv -----
// Shared constants, command codes and control/payload types of the column shader.
`default_nettype none

package rcfog_pkg;

  // Texture geometry (TEX_DIM is a power of two)
  localparam int TEX_DIM     = 64;
  localparam int TEX_COUNT   = 4;
  localparam int MAX_ROWS    = 1024;
  localparam int DIM_LOG2    = $clog2(TEX_DIM);
  localparam int TEX_AREA    = TEX_DIM * TEX_DIM;
  localparam int SIDE_W      = (TEX_COUNT > 1) ? $clog2(TEX_COUNT) : 1;
  localparam int STORE_DEPTH = TEX_COUNT * TEX_AREA;
  localparam int ADDR_W      = SIDE_W + 2 * DIM_LOG2;

  // Row counting
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);

  // Step divider: (TEX_DIM << 16) / h, one quotient bit per cycle
  localparam int DIV_BITS = DIM_LOG2 + 17;
  localparam int CNT_W    = $clog2(DIV_BITS);
  localparam int BASE_W   = 18;
  localparam int PROD_W   = BASE_W + DIV_BITS + 1;

  // Fog weight: min(2*(d-128)/29, 204)
  localparam int FOG_KNEE  = 128;
  localparam int FOG_DIV   = 29;
  localparam int FOG_MAX   = 204;
  localparam int FOG_LIMIT = (FOG_MAX + 1) * FOG_DIV;
  // Reciprocal of 29, exact for dividends below 2^18 / (FOG_RECIP*29 - 2^18)
  localparam int FOG_SHIFT = 18;
  localparam int FOG_RECIP = ((1 << FOG_SHIFT) + FOG_DIV - 1) / FOG_DIV;

  // Register reset values
  localparam logic [23:0] FOG_RESET  = 24'h6B4466;
  localparam logic [10:0] ROWS_RESET = 11'd480;

  // Stream widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  // Command codes (s_tuser)
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_SHADE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CEILING = 2'd0;
  localparam logic [1:0] CFG_FLOOR   = 2'd1;
  localparam logic [1:0] CFG_FOG     = 2'd2;
  localparam logic [1:0] CFG_ROWS    = 2'd3;

  // Input payload, last field in the lowest bits
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] wall_distance;
    logic [7:0]  texture_column;
    logic [15:0] wall_height;
    logic [9:0]  span_bottom;
    logic [9:0]  span_top;
    logic [23:0] texel_rgb;
    logic [11:0] texel_index;
    logic [1:0]  tex_side;
  } in_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;
    logic begin_start;
    logic shade_start;
    logic div_step;
    logic mul_en;
    logic sat_en;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/rcfog_ctrl.sv -----
// Sequencer for load, column setup (divide, multiply, saturate) and pixel shading.
`default_nettype none

module rcfog_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic [1:0]         s_tuser,
  output logic                    s_tready,
  input  wire rcfog_pkg::dp_stat_t stat,
  output rcfog_pkg::dp_cmd_t      cmd
);
  import rcfog_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_SAT, S_BLEND} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Command decode
  always_comb begin
    cmd             = '0;
    cmd.load_we     = accept && (s_tuser == CMD_LOAD);
    cmd.begin_start = accept && (s_tuser == CMD_BEGIN);
    cmd.shade_start = accept && (s_tuser == CMD_SHADE);
    cmd.div_step    = (state == S_DIV);
    cmd.mul_en      = (state == S_MUL);
    cmd.sat_en      = (state == S_SAT);
    cmd.out_load    = (state == S_BLEND) && stat.out_free;
  end

  // State and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (s_tuser)
              CMD_BEGIN: begin
                state <= S_DIV;
                cnt   <= '0;
              end
              CMD_SHADE: state <= S_BLEND;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_BITS - 1)) state <= S_MUL;
        end
        S_MUL:   state <= S_SAT;
        S_SAT:   state <= S_IDLE;
        S_BLEND: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rcfog_dp.sv -----
// Datapath: config registers, texture memory, step divider, fog weight, position, blend, output.
`default_nettype none

module rcfog_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire rcfog_pkg::in_item_t item,
  input  wire rcfog_pkg::dp_cmd_t cmd,
  output rcfog_pkg::dp_stat_t     stat,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [23:0]             out_rgb,
  output logic [9:0]              out_row,
  output logic                    out_last
);
  import rcfog_pkg::*;

  typedef enum logic [1:0] {K_CEIL, K_WALL, K_FLOOR} kind_t;

  localparam logic signed [PROD_W-1:0] PMAX = PROD_W'(2147483647);
  localparam logic signed [PROD_W-1:0] PMIN = -PMAX - 1;

  // Configuration
  logic [23:0] ceiling_rgb, floor_rgb, fog_rgb;
  logic [10:0] screen_rows;
  logic [ROWS_W-1:0] rows_eff;

  // Column state
  logic [9:0]          span_top, span_bottom;
  logic [SIDE_W-1:0]   sel_side;
  logic [DIM_LOG2-1:0] sel_col;
  logic [ROW_W-1:0]    row_counter;
  logic [31:0]         tex_pos;
  logic [DIV_BITS-1:0] tex_step;
  logic [7:0]          fog_w;

  // Setup arithmetic
  logic [15:0]               h_eff;
  logic signed [BASE_W-1:0]  base;
  logic [DIV_BITS-1:0]       div_num;
  logic [15:0]               div_rem;
  logic signed [PROD_W-1:0]  prod;

  // Pixel stage
  logic [23:0]      tex_mem [STORE_DEPTH];
  logic [23:0]      rd_data;
  kind_t            pix_kind;
  logic [9:0]       pix_row;
  logic             pix_last;

  // Combinational helpers
  logic [15:0]               h_in;
  logic                      load_ok;
  logic [ADDR_W-1:0]         wr_addr, rd_addr;
  logic [DIM_LOG2-1:0]       ty;
  logic [14:0]               pos_hi;
  logic [32:0]               pos_sum;
  logic                      last;
  logic [16:0]               rem_sh;
  logic [16:0]               fog_x;
  logic [25:0]               fog_prod;
  logic [7:0]                fog_calc;
  logic signed [DIV_BITS:0]  step_s;
  logic [15:0]               mix [3];
  logic [23:0]               blend_rgb;
  logic [23:0]               pix_color;

  assign stat.out_free = !out_valid || out_ready;

  // Effective row count: 0 acts as 1, clamp at MAX_ROWS
  always_comb begin
    if (screen_rows == '0) rows_eff = ROWS_W'(1);
    else if (32'(screen_rows) > MAX_ROWS) rows_eff = ROWS_W'(MAX_ROWS);
    else rows_eff = ROWS_W'(screen_rows);
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_rgb <= '0;
      floor_rgb   <= '0;
      fog_rgb     <= FOG_RESET;
      screen_rows <= ROWS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CEILING: ceiling_rgb <= cfg_data;
        CFG_FLOOR:   floor_rgb   <= cfg_data;
        CFG_FOG:     fog_rgb     <= cfg_data;
        CFG_ROWS:    screen_rows <= cfg_data[10:0];
      endcase
    end
  end

  // Texture memory: one write port, one registered read port
  assign load_ok = (32'(item.texel_index) < TEX_AREA) && (32'(item.tex_side) < TEX_COUNT);
  assign wr_addr = ADDR_W'(32'(item.tex_side) * TEX_AREA + 32'(item.texel_index));

  always_ff @(posedge clk) begin
    if (cmd.load_we && load_ok) tex_mem[wr_addr] <= item.texel_rgb;
  end

  // Texture row from position, clamped to 0..TEX_DIM-1
  assign pos_hi = tex_pos[30:16];
  always_comb begin
    if (tex_pos[31]) ty = '0;
    else if (32'(pos_hi) > TEX_DIM - 1) ty = DIM_LOG2'(TEX_DIM - 1);
    else ty = DIM_LOG2'(pos_hi);
  end
  assign rd_addr = {sel_side, ty, sel_col};

  always_ff @(posedge clk) begin
    if (cmd.shade_start) rd_data <= tex_mem[rd_addr];
  end

  // Divider step terms and fog dividend
  assign h_in    = (item.wall_height == '0) ? 16'd1 : item.wall_height;
  assign rem_sh  = {div_rem, div_num[DIV_BITS-1]};
  assign fog_x   = {item.wall_distance - 16'(FOG_KNEE), 1'b0};
  assign step_s  = signed'({1'b0, div_num});
  assign pos_sum = {tex_pos[31], tex_pos} + 33'(tex_step);
  assign last    = 32'(row_counter) >= 32'(rows_eff) - 32'd1;

  // Fog weight: divide by 29 through a reciprocal multiply, clamp to FOG_MAX
  assign fog_prod = 26'(fog_x[12:0]) * 26'(FOG_RECIP);
  always_comb begin
    if (32'(item.wall_distance) <= FOG_KNEE) fog_calc = '0;
    else if (32'(fog_x) >= FOG_LIMIT) fog_calc = 8'(FOG_MAX);
    else fog_calc = fog_prod[FOG_SHIFT +: 8];
  end

  // Column setup and per-pixel state
  always_ff @(posedge clk) begin
    if (rst) begin
      span_top    <= '0;
      span_bottom <= '0;
      sel_side    <= '0;
      sel_col     <= '0;
      row_counter <= '0;
      tex_pos     <= '0;
      tex_step    <= '0;
      fog_w       <= '0;
    end else begin
      if (cmd.begin_start) begin
        span_top    <= item.span_top;
        span_bottom <= item.span_bottom;
        sel_side    <= (32'(item.tex_side) >= TEX_COUNT) ? SIDE_W'(TEX_COUNT - 1)
                                                         : SIDE_W'(item.tex_side);
        sel_col     <= (32'(item.texture_column) > TEX_DIM - 1) ? DIM_LOG2'(TEX_DIM - 1)
                                                                : DIM_LOG2'(item.texture_column);
        row_counter <= '0;
        fog_w       <= fog_calc;
      end
      if (cmd.mul_en) tex_step <= div_num;
      if (cmd.sat_en) begin
        if (prod > PMAX) tex_pos <= 32'h7FFF_FFFF;
        else if (prod < PMIN) tex_pos <= 32'h8000_0000;
        else tex_pos <= prod[31:0];
      end
      if (cmd.shade_start) begin
        row_counter <= last ? '0 : row_counter + 1'b1;
        // Advance along the texture on wall rows, saturating at the top
        if (32'(row_counter) >= 32'(span_top) && 32'(row_counter) <= 32'(span_bottom)) begin
          if (!pos_sum[32] && pos_sum[31]) tex_pos <= 32'h7FFF_FFFF;
          else tex_pos <= pos_sum[31:0];
        end
      end
    end
  end

  // Restoring divider for the texture step, one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.begin_start) begin
      h_eff   <= h_in;
      base    <= BASE_W'(int'(item.span_top) - int'(rows_eff >> 1) + int'(h_in >> 1));
      div_num <= DIV_BITS'(1) << (DIM_LOG2 + 16);
      div_rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, h_eff}) begin
        div_rem <= 16'(rem_sh - {1'b0, h_eff});
        div_num <= {div_num[DIV_BITS-2:0], 1'b1};
      end else begin
        div_rem <= rem_sh[15:0];
        div_num <= {div_num[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  // Start position product, registered before saturation
  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= base * step_s;
  end

  // Pixel classification at acceptance
  always_ff @(posedge clk) begin
    if (cmd.shade_start) begin
      pix_row  <= 10'(row_counter);
      pix_last <= last;
      if (32'(row_counter) < 32'(span_top)) pix_kind <= K_CEIL;
      else if (32'(row_counter) <= 32'(span_bottom)) pix_kind <= K_WALL;
      else pix_kind <= K_FLOOR;
    end
  end

  // Fog blend per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix[c] = 16'(rd_data[c*8 +: 8]) * 16'(9'd256 - 9'(fog_w))
             + 16'(fog_rgb[c*8 +: 8]) * 16'(fog_w);
      blend_rgb[c*8 +: 8] = mix[c][15:8];
    end
  end

  always_comb begin
    unique case (pix_kind)
      K_CEIL:  pix_color = ceiling_rgb;
      K_WALL:  pix_color = blend_rgb;
      K_FLOOR: pix_color = floor_rgb;
      default: pix_color = floor_rgb;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rgb  <= pix_color;
      out_row  <= pix_row;
      out_last <= pix_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/raycast_column_texture_fog_shader.sv -----
// Sequencing: a texel load is written at acceptance; a column begin runs a divide phase on
//   the one-bit-per-cycle restoring divider for the texture step, then multiply and saturate.
// Pixel: texture memory read at acceptance, blend in the next cycle; the result enters the
//   output register once that register is free, and no new input is accepted before then.
//   The output register frees the input.
// Reset (rst, synchronous): clears control state and config to documented defaults;
//   the texture memory is not cleared and holds garbage until loaded.
`default_nettype none

module raycast_column_texture_fog_shader (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [23:0]                         cfg_data,
  // Input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // tex_side[1:0], texel_index[13:2], texel_rgb[37:14], span_top[47:38],
  // span_bottom[57:48], wall_height[73:58], texture_column[81:74], wall_distance[97:82]
  input  wire logic [rcfog_pkg::IN_DATA_W-1:0]     s_tdata,
  // command[1:0]
  input  wire logic [1:0]                          s_tuser,
  // Output stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // pixel_rgb[23:0], pixel_row[33:24]
  output logic [rcfog_pkg::OUT_DATA_W-1:0]         m_tdata,
  // column_done
  output logic                                     m_tlast
);
  import rcfog_pkg::*;

  in_item_t    item;
  dp_cmd_t     ctl_cmd;
  dp_stat_t    ctl_stat;
  logic [23:0] out_rgb;
  logic [9:0]  out_row;

  assign item = in_item_t'(s_tdata);

  rcfog_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  rcfog_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (ctl_cmd),
    .stat      (ctl_stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_rgb   (out_rgb),
    .out_row   (out_row),
    .out_last  (m_tlast)
  );

  assign m_tdata = OUT_DATA_W'({out_row, out_rgb});

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while full");

  // Setup phases and transaction starts never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl_cmd.load_we, ctl_cmd.begin_start, ctl_cmd.shade_start,
              ctl_cmd.div_step, ctl_cmd.mul_en, ctl_cmd.sat_en}))
    else $error("overlapping datapath phases");

  // A shade transaction occupies the block for its blend cycle
  a_shade_busy: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.shade_start |=> !s_tready)
    else $error("input accepted during blend");

endmodule

`default_nettype wire

// ----- dv/raycast_column_texture_fog_shader_test.sv -----
// Self-checking stream testbench for the raycast column texture/fog shader.
`timescale 1ns / 100ps

module raycast_column_texture_fog_shader_test;
  import rcfog_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [23:0] rgb;
    logic [9:0]  row;
    logic        done;
  } pixel_t;

  // Shadow of the shader state; predicts pixels and checks them in order
  class shade_scoreboard;
    logic [23:0] texels [STORE_DEPTH];
    bit          texel_loaded [STORE_DEPTH];
    logic [23:0] ceiling_rgb = 24'h0;
    logic [23:0] floor_rgb = 24'h0;
    logic [23:0] fog_rgb = FOG_RESET;
    logic [10:0] rows_reg = ROWS_RESET;
    int          row_count;
    longint      tex_pos;
    longint      tex_step;
    int          fog_w;
    int          top_q, bot_q, sel_tex, sel_col;
    pixel_t      expected_pixels[$];
    int          errors;

    function int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function bit column_ready(int side, int col);
      for (int r = 0; r < TEX_DIM; r++)
        if (!texel_loaded[side * TEX_AREA + r * TEX_DIM + col]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] value);
      case (idx)
        CFG_CEILING: ceiling_rgb = value;
        CFG_FLOOR:   floor_rgb = value;
        CFG_FOG:     fog_rgb = value;
        CFG_ROWS:    rows_reg = value[10:0];
        default: ;
      endcase
    endfunction

    // per channel: (texel*(256-w) + fog*w) >> 8
    function logic [23:0] fogged(logic [23:0] texel);
      logic [23:0] mix;
      int a, b;
      for (int s = 0; s < 24; s += 8) begin
        a = texel[s+:8];
        b = fog_rgb[s+:8];
        mix[s+:8] = 8'((a * (256 - fog_w) + b * fog_w) >> 8);
      end
      return mix;
    endfunction

    // Called once per accepted input transaction
    function void absorb_command(logic [1:0] cmd, in_item_t it);
      int idx, h, wall_dist, rows, r, ty;
      longint prod, next_pos;
      logic [23:0] color;
      bit last;
      case (cmd)
        CMD_LOAD: begin
          if (it.tex_side < TEX_COUNT && it.texel_index < TEX_AREA) begin
            idx = it.tex_side * TEX_AREA + it.texel_index;
            texels[idx] = it.texel_rgb;
            texel_loaded[idx] = 1'b1;
          end
        end
        CMD_BEGIN: begin
          h = (it.wall_height == 0) ? 1 : it.wall_height;
          tex_step = (longint'(TEX_DIM) << 16) / h;
          prod = (longint'(it.span_top) - eff_rows() / 2 + h / 2) * tex_step;
          if (prod > POS_MAX) prod = POS_MAX;
          if (prod < POS_MIN) prod = POS_MIN;
          tex_pos = prod;
          wall_dist = it.wall_distance;
          if (wall_dist <= 128) fog_w = 0;
          else fog_w = (2 * (wall_dist - 128)) / 29;
          if (fog_w > FOG_MAX) fog_w = FOG_MAX;
          top_q = it.span_top;
          bot_q = it.span_bottom;
          sel_tex = (it.tex_side >= TEX_COUNT) ? TEX_COUNT - 1 : it.tex_side;
          sel_col = (it.texture_column > TEX_DIM - 1) ? TEX_DIM - 1 : it.texture_column;
          row_count = 0;
        end
        CMD_SHADE: begin
          rows = eff_rows();
          r = row_count;
          last = (r >= rows - 1);
          if (r < top_q) begin
            color = ceiling_rgb;
          end else if (r <= bot_q) begin
            ty = (tex_pos < 0) ? 0 : int'(tex_pos >>> 16);
            if (ty > TEX_DIM - 1) ty = TEX_DIM - 1;
            color = fogged(texels[sel_tex * TEX_AREA + ty * TEX_DIM + sel_col]);
            next_pos = tex_pos + tex_step;
            tex_pos = (next_pos > POS_MAX) ? POS_MAX : next_pos;
          end else begin
            color = floor_rgb;
          end
          expected_pixels.push_back('{rgb: color, row: 10'(r), done: last});
          row_count = last ? 0 : r + 1;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    // Called once per accepted output transaction
    task check_pixel(logic [OUT_DATA_W-1:0] data, logic done);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel row %0d", data[33:24]));
        return;
      end
      want = expected_pixels.pop_front();
      if (data[23:0] !== want.rgb)
        report_mismatch($sformatf("row %0d rgb %h, want %h", want.row, data[23:0], want.rgb));
      if (data[33:24] !== want.row)
        report_mismatch($sformatf("row %0d, want %0d", data[33:24], want.row));
      if (done !== want.done)
        report_mismatch($sformatf("row %0d column_done %b, want %b", want.row, done,
                                  want.done));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [1:0]            cfg_index = CFG_CEILING;
  logic [23:0]           cfg_data = 24'h0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = CMD_LOAD;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  shade_scoreboard sb = new();
  int send_idle_pct = 19;
  int recv_idle_pct = 49;
  int items_left;
  bit hold_request = 1'b0;
  int hold_left = 0;

  raycast_column_texture_fog_shader dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Output side: check each transaction, random back-pressure, long hold on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_pixel(m_tdata, m_tlast);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t random_payload();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, 8'd0});
    it.pad = '0;
    return it;
  endfunction

  function automatic in_item_t texel_item(int side, int idx, logic [23:0] rgb);
    in_item_t it;
    it = '0;
    it.tex_side = 2'(side);
    it.texel_index = 12'(idx);
    it.texel_rgb = rgb;
    return it;
  endfunction

  function automatic in_item_t column_item(int side, int top, int bot, int h, int col,
                                           int wall_dist);
    in_item_t it;
    it = '0;
    it.tex_side = 2'(side);
    it.span_top = 10'(top);
    it.span_bottom = 10'(bot);
    it.wall_height = 16'(h);
    it.texture_column = 8'(col);
    it.wall_distance = 16'(wall_dist);
    return it;
  endfunction

  // One input transaction, with random idle cycles ahead of it
  task automatic send(input logic [1:0] cmd, input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= it;
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.absorb_command(cmd, it);
    if (cmd != CMD_UNKNOWN) items_left--;
  endtask

  task automatic send_shades(input int count);
    for (int k = 0; k < count; k++) send(CMD_SHADE, random_payload());
  endtask

  // Sender pauses until every pixel is back, then lets the divider settle
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [23:0] ceil_v, input logic [23:0] floor_v,
                           input logic [23:0] fog_v, input logic [10:0] rows_v);
    logic [1:0]  regs [4];
    logic [23:0] vals [4];
    regs = '{CFG_CEILING, CFG_FLOOR, CFG_FOG, CFG_ROWS};
    vals = '{ceil_v, floor_v, fog_v, {13'd0, rows_v}};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Fill one whole texture column so that any row of it may be fetched
  task automatic load_texture_column(input int side, input int col);
    logic [23:0] rgb;
    for (int r = 0; r < TEX_DIM; r++) begin
      case ($urandom_range(7))
        0: rgb = 24'h000000;
        1: rgb = 24'hFFFFFF;
        default: rgb = 24'($urandom);
      endcase
      send(CMD_LOAD, texel_item(side, r * TEX_DIM + col, rgb));
    end
  endtask

  // Begin a column with random geometry, then shade part of it, all of it, or past the end
  task automatic render_column(input bit full);
    int rows, side, top, bot, span, h, col, wall_dist, count;
    rows = sb.eff_rows();
    side = $urandom_range(TEX_COUNT - 1);
    case ($urandom_range(3))
      0: top = 0;
      1: top = $urandom_range(1023);
      default: top = $urandom_range(rows);
    endcase
    if (top > 1023) top = 1023;
    case ($urandom_range(5))
      0: bot = (top == 0) ? 0 : top - 1;
      1: bot = 1023;
      2: bot = $urandom_range(1023);
      default: bot = top + $urandom_range(rows);
    endcase
    if (bot > 1023) bot = 1023;
    span = (bot >= top) ? bot - top + 1 : 1;
    case ($urandom_range(7))
      0: h = 0;
      1: h = 1;
      2: h = 65535;
      3: h = $urandom_range(65535);
      default: h = span - span / 4 + $urandom_range(span / 2 + 8);
    endcase
    if (h > 65535) h = 65535;
    case ($urandom_range(3))
      0: wall_dist = $urandom_range(128);
      1: wall_dist = $urandom_range(6100, 129);
      2: wall_dist = $urandom_range(65535);
      default: wall_dist = $urandom_range(3000, 300);
    endcase
    col = $urandom_range(255);
    if (!sb.column_ready(side, (col > TEX_DIM - 1) ? TEX_DIM - 1 : col))
      col = $urandom_range(1) ? 0 : $urandom_range(255, TEX_DIM);
    send(CMD_BEGIN, column_item(side, top, bot, h, col, wall_dist));
    if (full) begin
      count = rows;
    end else begin
      case ($urandom_range(3))
        0: count = $urandom_range(rows, 1);
        1: count = rows + $urandom_range(3, 1);
        default: count = rows;
      endcase
    end
    for (int k = 0; k < count && items_left > 0; k++)
      send(CMD_SHADE, random_payload());
  endtask

  // Stray loads, stray shades and unknown commands
  task automatic noise();
    case ($urandom_range(2))
      0: send(CMD_LOAD, texel_item($urandom_range(TEX_COUNT - 1), $urandom_range(4095),
                                   24'($urandom)));
      1: send_shades($urandom_range(3, 1));
      default: send(CMD_UNKNOWN, random_payload());
    endcase
  endtask

  task automatic run_phase(input int budget, input bit first_full);
    int pick;
    items_left = budget;
    if (first_full) render_column(1'b1);
    while (items_left > 0) begin
      pick = $urandom_range(99);
      if (pick < 70) render_column(1'b0);
      else if (pick < 80)
        load_texture_column($urandom_range(TEX_COUNT - 1), $urandom_range(TEX_DIM - 1));
      else noise();
    end
  endtask

  // Stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edge columns of every texture, so clamped columns always fetch loaded texels
    for (int side = 0; side < TEX_COUNT; side++) begin
      load_texture_column(side, 0);
      load_texture_column(side, TEX_DIM - 1);
    end
    send(CMD_LOAD, texel_item(TEX_COUNT - 1, 4095, 24'hFFFFFF));

    // directed: reset register values, special cases and field extremes
    send(CMD_UNKNOWN, random_payload());
    // zero height, oversize column, far wall: full fog
    send(CMD_BEGIN, column_item(0, 0, 1023, 0, 255, 65535));
    send_shades(3);
    // empty span, tallest wall, fog knee
    send(CMD_BEGIN, column_item(1, 1023, 0, 65535, 0, 128));
    send_shades(2);
    // ceiling, wall and floor in one short column
    send(CMD_BEGIN, column_item(3, 2, 5, 4, TEX_DIM - 1, 129));
    send_shades(3);
    send(CMD_UNKNOWN, random_payload());
    send_shades(5);
    // one-row wall, no fog
    send(CMD_BEGIN, column_item(2, 0, 0, 1, TEX_DIM - 1, 0));
    send_shades(2);

    wait_drain();
    configure(24'hFFFFFF, 24'h000000, 24'h000000, 11'd23);
    hold_request = 1'b1;
    run_phase(50, 1'b1);

    wait_drain();
    configure(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 11'd1);
    run_phase(40, 1'b0);

    send_idle_pct = 49;
    recv_idle_pct = 19;
    wait_drain();
    configure(24'($urandom), 24'($urandom), 24'($urandom), 11'd1024);
    run_phase(1030, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drain();
    configure(24'($urandom), 24'($urandom), FOG_RESET, 11'd0);
    run_phase(40, 1'b0);

    wait_drain();
    configure(24'($urandom), 24'($urandom), 24'($urandom), 11'd2047);
    run_phase(20, 1'b0);

    wait_drain();
    configure(24'($urandom), 24'($urandom), 24'($urandom), 11'd64);
    run_phase(50, 1'b0);

    wait_drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
